/* hw/rtl/c128b_pkg.sv */
// Shared types, constants and the symbol pattern table for the Code 128 set B encoder.
// No dependencies; imported by the top level, the front and the back.

package c128b_pkg;

    localparam logic [7:0]  CODE_FIRST     = 8'd32;
    localparam logic [7:0]  CODE_LAST      = 8'd126;
    localparam logic [6:0]  CHECK_MOD      = 7'd103;
    localparam logic [6:0]  START_VALUE    = 7'd1;
    localparam logic [3:0]  QUIET_MODULES  = 4'd11;
    localparam logic [3:0]  SYMBOL_MODULES = 4'd11;
    localparam logic [3:0]  STOP_MODULES   = 4'd13;
    localparam logic [3:0]  ERROR_MODULES  = 4'd0;
    localparam logic [10:0] START_B_BITS   = 11'b11010010000;
    localparam logic [12:0] STOP_BITS      = 13'b1100011101011;

    // One classified input word as it travels down the front pipeline.
    typedef struct packed {
        logic       err;
        logic       open;
        logic       last;
        logic [6:0] value;
    } item_t;

    // One command word between the front and the back.
    typedef struct packed {
        logic       err;
        logic       open;
        logic       last;
        logic [6:0] value;
        logic [6:0] check;
    } cmd_t;

    typedef struct packed {
        logic [12:0] pattern;
        logic [3:0]  module_count;
        logic        error;
        logic        last_result;
    } result_t;

    typedef enum logic [2:0] {
        BK_HEAD,
        BK_START,
        BK_DATA,
        BK_CHECK,
        BK_STOP,
        BK_QUIET
    } back_step_t;

    function automatic logic [10:0] sym_pattern(input logic [6:0] v);
        logic [10:0] p;
        case (v)
            7'd0:   p = 11'b11011001100;
            7'd1:   p = 11'b11001101100;
            7'd2:   p = 11'b11001100110;
            7'd3:   p = 11'b10010011000;
            7'd4:   p = 11'b10010001100;
            7'd5:   p = 11'b10001001100;
            7'd6:   p = 11'b10011001000;
            7'd7:   p = 11'b10011000100;
            7'd8:   p = 11'b10001100100;
            7'd9:   p = 11'b11001001000;
            7'd10:  p = 11'b11001000100;
            7'd11:  p = 11'b11000100100;
            7'd12:  p = 11'b10110011100;
            7'd13:  p = 11'b10011011100;
            7'd14:  p = 11'b10011001110;
            7'd15:  p = 11'b10111001100;
            7'd16:  p = 11'b10011101100;
            7'd17:  p = 11'b10011100110;
            7'd18:  p = 11'b11001110010;
            7'd19:  p = 11'b11001011100;
            7'd20:  p = 11'b11001001110;
            7'd21:  p = 11'b11011100100;
            7'd22:  p = 11'b11001110100;
            7'd23:  p = 11'b11101101110;
            7'd24:  p = 11'b11101001100;
            7'd25:  p = 11'b11100101100;
            7'd26:  p = 11'b11100100110;
            7'd27:  p = 11'b11101100100;
            7'd28:  p = 11'b11100110100;
            7'd29:  p = 11'b11100110010;
            7'd30:  p = 11'b11011011000;
            7'd31:  p = 11'b11011000110;
            7'd32:  p = 11'b11000110110;
            7'd33:  p = 11'b10100011000;
            7'd34:  p = 11'b10001011000;
            7'd35:  p = 11'b10001000110;
            7'd36:  p = 11'b10110001000;
            7'd37:  p = 11'b10001101000;
            7'd38:  p = 11'b10001100010;
            7'd39:  p = 11'b11010001000;
            7'd40:  p = 11'b11000101000;
            7'd41:  p = 11'b11000100010;
            7'd42:  p = 11'b10110111000;
            7'd43:  p = 11'b10110001110;
            7'd44:  p = 11'b10001101110;
            7'd45:  p = 11'b10111011000;
            7'd46:  p = 11'b10111000110;
            7'd47:  p = 11'b10001110110;
            7'd48:  p = 11'b11101110110;
            7'd49:  p = 11'b11010001110;
            7'd50:  p = 11'b11000101110;
            7'd51:  p = 11'b11011101000;
            7'd52:  p = 11'b11011100010;
            7'd53:  p = 11'b11011101110;
            7'd54:  p = 11'b11101011000;
            7'd55:  p = 11'b11101000110;
            7'd56:  p = 11'b11100010110;
            7'd57:  p = 11'b11101101000;
            7'd58:  p = 11'b11101100010;
            7'd59:  p = 11'b11100011010;
            7'd60:  p = 11'b11101111010;
            7'd61:  p = 11'b11001000010;
            7'd62:  p = 11'b11110001010;
            7'd63:  p = 11'b10100110000;
            7'd64:  p = 11'b10100001100;
            7'd65:  p = 11'b10010110000;
            7'd66:  p = 11'b10010000110;
            7'd67:  p = 11'b10000101100;
            7'd68:  p = 11'b10000100110;
            7'd69:  p = 11'b10110010000;
            7'd70:  p = 11'b10110000100;
            7'd71:  p = 11'b10011010000;
            7'd72:  p = 11'b10011000010;
            7'd73:  p = 11'b10000110100;
            7'd74:  p = 11'b10000110010;
            7'd75:  p = 11'b11000010010;
            7'd76:  p = 11'b11001010000;
            7'd77:  p = 11'b11110111010;
            7'd78:  p = 11'b11000010100;
            7'd79:  p = 11'b10001111010;
            7'd80:  p = 11'b10100111100;
            7'd81:  p = 11'b10010111100;
            7'd82:  p = 11'b10010011110;
            7'd83:  p = 11'b10111100100;
            7'd84:  p = 11'b10011110100;
            7'd85:  p = 11'b10011110010;
            7'd86:  p = 11'b11110100100;
            7'd87:  p = 11'b11110010100;
            7'd88:  p = 11'b11110010010;
            7'd89:  p = 11'b11011011110;
            7'd90:  p = 11'b11011110110;
            7'd91:  p = 11'b11110110110;
            7'd92:  p = 11'b10101111000;
            7'd93:  p = 11'b10100011110;
            7'd94:  p = 11'b10001011110;
            7'd95:  p = 11'b10111101000;
            7'd96:  p = 11'b10111100010;
            7'd97:  p = 11'b11110101000;
            7'd98:  p = 11'b11110100010;
            7'd99:  p = 11'b10111011110;
            7'd100: p = 11'b10111101110;
            7'd101: p = 11'b11101011110;
            7'd102: p = 11'b11110101110;
            default: p = 11'b00000000000;
        endcase
        return p;
    endfunction

endpackage

/* hw/rtl/code128b_symbol_encoder.sv */
// Top level of the Code 128 set B symbol encoder: front, command queue, back and
// result queue. Depends on c128b_pkg, c128b_front, c128b_queue and c128b_back.
//
// Input channel: a word (char_code, last_char) is taken at a clock edge with push high
// and full low. Each message's first word is preceded by a quiet zone and Start B; the
// last word is followed by the check symbol, Stop and a closing quiet zone.
// An unencodable character gives one error word marked last_result, and the rest of
// that message, up to its last_char, is dropped without results.
// Result channel: the oldest word sits on pattern, module_count, error and last_result
// while empty is low and is taken at an edge with pop high and empty low.
// Throughput: one character per cycle while full is low; one result word per cycle
// while the back has a command and room. A message start adds two result words and a
// message end three, absorbed by the command queue.
// When the receiver stalls, the result queue fills, the back holds, and full rises once
// the command queue has no room for the words in the four-stage checksum pipeline.
// Reset clears both queues, the message and skip state, and the checksum.

module code128b_symbol_encoder import c128b_pkg::*; #(
    parameter int CMD_DEPTH = 8,
    parameter int OUT_DEPTH = 4
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic [7:0]  char_code,
    input  logic        last_char,
    output logic        empty,
    input  logic        pop,
    output logic [12:0] pattern,
    output logic [3:0]  module_count,
    output logic        error,
    output logic        last_result
);

    localparam int CMD_CNT_W = $clog2(CMD_DEPTH + 1);
    localparam int OUT_CNT_W = $clog2(OUT_DEPTH + 1);

    logic                 cmd_push;
    cmd_t                 cmd_in;
    logic [$bits(cmd_t)-1:0] cmd_out_bits;
    cmd_t                 cmd_head;
    logic                 cmd_empty;
    logic                 cmd_pop;
    logic [CMD_CNT_W-1:0] cmd_count;

    logic                 out_push;
    result_t              out_in;
    logic [$bits(result_t)-1:0] out_bits;
    result_t              out_head;
    logic [OUT_CNT_W-1:0] out_count;
    logic                 out_full;

    assign cmd_head = cmd_out_bits;
    assign out_head = out_bits;
    assign out_full = (out_count == OUT_CNT_W'(OUT_DEPTH));

    assign pattern      = out_head.pattern;
    assign module_count = out_head.module_count;
    assign error        = out_head.error;
    assign last_result  = out_head.last_result;

    c128b_front #(
        .CMD_DEPTH (CMD_DEPTH)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .char_code (char_code),
        .last_char (last_char),
        .cmd_count (cmd_count),
        .cmd_push  (cmd_push),
        .cmd_data  (cmd_in)
    );

    c128b_queue #(
        .DEPTH (CMD_DEPTH),
        .WIDTH ($bits(cmd_t))
    ) u_cmd_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (cmd_push),
        .wdata (cmd_in),
        .pop   (cmd_pop),
        .rdata (cmd_out_bits),
        .empty (cmd_empty),
        .count (cmd_count)
    );

    c128b_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_empty (cmd_empty),
        .cmd_head  (cmd_head),
        .out_full  (out_full),
        .cmd_pop   (cmd_pop),
        .out_push  (out_push),
        .out_word  (out_in)
    );

    c128b_queue #(
        .DEPTH (OUT_DEPTH),
        .WIDTH ($bits(result_t))
    ) u_out_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (out_push),
        .wdata (out_in),
        .pop   (pop),
        .rdata (out_bits),
        .empty (empty),
        .count (out_count)
    );

endmodule

/* hw/rtl/c128b_queue.sv */
// Small first-in first-out queue of fixed-width words with an occupancy count.
// No dependencies; used between front and back and as the result buffer.

module c128b_queue #(
    parameter int DEPTH = 4,
    parameter int WIDTH = 8,
    localparam int CNT_W = $clog2(DEPTH + 1),
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wdata,
    input  logic             pop,
    output logic [WIDTH-1:0] rdata,
    output logic             empty,
    output logic [CNT_W-1:0] count
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             wr_en;
    logic             rd_en;

    assign empty = (count_reg == '0);
    assign count = count_reg;
    assign rdata = mem_reg[rd_ptr_reg];
    assign wr_en = push && (count_reg != CNT_W'(DEPTH));
    assign rd_en = pop && !empty;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (wr_en)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (rd_en)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (wr_en && !rd_en)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (rd_en && !wr_en)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_ptr_reg] <= wdata;
        end
    end

endmodule

/* hw/rtl/c128b_front.sv */
// Front of the encoder: accepts characters, tracks message and skip state, and
// accumulates the checksum in a short pipeline. Depends on c128b_pkg.

module c128b_front import c128b_pkg::*; #(
    parameter int CMD_DEPTH = 8,
    localparam int CNT_W = $clog2(CMD_DEPTH + 1),
    localparam int SUM_W = $clog2(CMD_DEPTH + 5)
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    output logic             full,
    input  logic [7:0]       char_code,
    input  logic             last_char,
    input  logic [CNT_W-1:0] cmd_count,
    output logic             cmd_push,
    output cmd_t             cmd_data
);

    logic        in_message_reg;
    logic        in_message_next;
    logic        skipping_reg;
    logic        skipping_next;
    logic [6:0]  pos_reg;
    logic [6:0]  pos_next;
    logic [6:0]  cs_reg;
    logic [6:0]  cs_next;

    logic        s1_valid_reg;
    logic        s1_valid_next;
    item_t       s1_item_reg;
    item_t       s1_item_next;
    logic [6:0]  s1_pos_reg;

    logic        s2_valid_reg;
    item_t       s2_item_reg;
    logic [13:0] s2_prod_reg;
    logic [13:0] s2_prod_next;

    logic        s3_valid_reg;
    item_t       s3_item_reg;
    logic [9:0]  s3_fold_reg;
    logic [9:0]  s3_fold_next;
    logic [11:0] fold_one;

    logic        s4_valid_reg;
    item_t       s4_item_reg;
    logic [6:0]  s4_rem_reg;
    logic [6:0]  s4_rem_next;
    logic [8:0]  fold_three;
    logic [8:0]  rem_a;
    logic [8:0]  rem_b;

    logic [SUM_W-1:0] pending;
    logic        accept;
    logic        char_ok;
    logic        opens;
    logic [6:0]  base;
    logic [7:0]  sum;

    // Words in flight count against free room in the command queue.
    assign pending = SUM_W'(cmd_count) + SUM_W'(s1_valid_reg) + SUM_W'(s2_valid_reg)
                   + SUM_W'(s3_valid_reg) + SUM_W'(s4_valid_reg);
    assign full    = (pending >= SUM_W'(CMD_DEPTH));
    assign accept  = push && !full;
    assign char_ok = (char_code >= CODE_FIRST) && (char_code <= CODE_LAST);
    assign opens   = !in_message_reg;

    always_comb
    begin
        in_message_next    = in_message_reg;
        skipping_next      = skipping_reg;
        pos_next           = pos_reg;
        s1_valid_next      = 1'b0;
        s1_item_next.err   = !char_ok;
        s1_item_next.open  = opens;
        s1_item_next.last  = last_char;
        s1_item_next.value = 7'(char_code - CODE_FIRST);
        if (accept)
        begin
            if (skipping_reg)
            begin
                if (last_char)
                begin
                    skipping_next = 1'b0;
                end
            end
            else if (!char_ok)
            begin
                s1_valid_next   = 1'b1;
                in_message_next = 1'b0;
                skipping_next   = !last_char;
            end
            else
            begin
                s1_valid_next   = 1'b1;
                in_message_next = !last_char;
                if (opens)
                begin
                    pos_next = 7'd1;
                end
                else if (pos_reg == CHECK_MOD - 7'd1)
                begin
                    pos_next = '0;
                end
                else
                begin
                    pos_next = pos_reg + 7'd1;
                end
            end
        end
    end

    // The product is reduced modulo 103 by folding: 128 is 25 modulo 103.
    assign s2_prod_next = 14'(s1_pos_reg) * 14'(s1_item_reg.value);
    assign fold_one     = 12'(s2_prod_reg[13:7]) * 12'd25 + 12'(s2_prod_reg[6:0]);
    assign s3_fold_next = 10'(fold_one[11:7]) * 10'd25 + 10'(fold_one[6:0]);
    assign fold_three   = 9'(s3_fold_reg[9:7]) * 9'd25 + 9'(s3_fold_reg[6:0]);
    assign rem_a        = (fold_three >= 9'(CHECK_MOD)) ? fold_three - 9'(CHECK_MOD)
                                                        : fold_three;
    assign rem_b        = (rem_a >= 9'(CHECK_MOD)) ? rem_a - 9'(CHECK_MOD) : rem_a;
    assign s4_rem_next  = rem_b[6:0];

    assign base    = s4_item_reg.open ? START_VALUE : cs_reg;
    assign sum     = 8'(base) + 8'(s4_rem_reg);
    assign cs_next = (sum >= 8'(CHECK_MOD)) ? 7'(sum - 8'(CHECK_MOD)) : sum[6:0];

    assign cmd_push       = s4_valid_reg;
    assign cmd_data.err   = s4_item_reg.err;
    assign cmd_data.open  = s4_item_reg.open;
    assign cmd_data.last  = s4_item_reg.last;
    assign cmd_data.value = s4_item_reg.value;
    assign cmd_data.check = cs_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_message_reg <= 1'b0;
            skipping_reg   <= 1'b0;
            pos_reg        <= '0;
            cs_reg         <= START_VALUE;
            s1_valid_reg   <= 1'b0;
            s2_valid_reg   <= 1'b0;
            s3_valid_reg   <= 1'b0;
            s4_valid_reg   <= 1'b0;
        end
        else
        begin
            in_message_reg <= in_message_next;
            skipping_reg   <= skipping_next;
            pos_reg        <= pos_next;
            s1_valid_reg   <= s1_valid_next;
            s2_valid_reg   <= s1_valid_reg;
            s3_valid_reg   <= s2_valid_reg;
            s4_valid_reg   <= s3_valid_reg;
            if (s4_valid_reg && !s4_item_reg.err)
            begin
                cs_reg <= cs_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        s1_item_reg <= s1_item_next;
        s1_pos_reg  <= pos_next;
        s2_item_reg <= s1_item_reg;
        s2_prod_reg <= s2_prod_next;
        s3_item_reg <= s2_item_reg;
        s3_fold_reg <= s3_fold_next;
        s4_item_reg <= s3_item_reg;
        s4_rem_reg  <= s4_rem_next;
    end

endmodule

/* hw/rtl/c128b_back.sv */
// Back of the encoder: expands each command word into one to six result words.
// Depends on c128b_pkg.

module c128b_back import c128b_pkg::*; (
    input  logic    clk,
    input  logic    rst_n,
    input  logic    cmd_empty,
    input  cmd_t    cmd_head,
    input  logic    out_full,
    output logic    cmd_pop,
    output logic    out_push,
    output result_t out_word
);

    back_step_t step_reg;
    back_step_t step_next;
    logic       go;
    logic       done;

    assign go = !cmd_empty && !out_full;

    always_comb
    begin
        step_next = step_reg;
        if (go)
        begin
            case (step_reg)
                BK_HEAD:
                begin
                    if (cmd_head.err)
                    begin
                        step_next = BK_HEAD;
                    end
                    else if (cmd_head.open)
                    begin
                        step_next = BK_START;
                    end
                    else if (cmd_head.last)
                    begin
                        step_next = BK_CHECK;
                    end
                    else
                    begin
                        step_next = BK_HEAD;
                    end
                end
                BK_START: step_next = BK_DATA;
                BK_DATA:  step_next = cmd_head.last ? BK_CHECK : BK_HEAD;
                BK_CHECK: step_next = BK_STOP;
                BK_STOP:  step_next = BK_QUIET;
                BK_QUIET: step_next = BK_HEAD;
                default:  step_next = BK_HEAD;
            endcase
        end
    end

    always_comb
    begin
        out_word.pattern      = {2'b00, sym_pattern(cmd_head.value)};
        out_word.module_count = SYMBOL_MODULES;
        out_word.error        = 1'b0;
        out_word.last_result  = 1'b0;
        done                  = 1'b0;
        case (step_reg)
            BK_HEAD:
            begin
                if (cmd_head.err)
                begin
                    out_word.pattern      = '0;
                    out_word.module_count = ERROR_MODULES;
                    out_word.error        = 1'b1;
                    out_word.last_result  = 1'b1;
                    done                  = 1'b1;
                end
                else if (cmd_head.open)
                begin
                    out_word.pattern      = '0;
                    out_word.module_count = QUIET_MODULES;
                end
                else
                begin
                    done = !cmd_head.last;
                end
            end
            BK_START:
            begin
                out_word.pattern = {2'b00, START_B_BITS};
            end
            BK_DATA:
            begin
                done = !cmd_head.last;
            end
            BK_CHECK:
            begin
                out_word.pattern = {2'b00, sym_pattern(cmd_head.check)};
            end
            BK_STOP:
            begin
                out_word.pattern      = STOP_BITS;
                out_word.module_count = STOP_MODULES;
            end
            BK_QUIET:
            begin
                out_word.pattern      = '0;
                out_word.module_count = QUIET_MODULES;
                out_word.last_result  = 1'b1;
                done                  = 1'b1;
            end
            default:
            begin
                done = 1'b0;
            end
        endcase
        out_push = go;
        cmd_pop  = go && done;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= BK_HEAD;
        end
        else
        begin
            step_reg <= step_next;
        end
    end

endmodule
